>>> design/vps_pkg.sv
package vps_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int DT_W     = 31;
  localparam int LOSS_W   = 17;
  localparam int BOUND_W  = 31;
  localparam int MASS_W   = 31;
  localparam int CFG_IDX_W = 2;

  // Quotient magnitude width of the fixed-point dividers: |(p - l) * 2^16| < 2^48.
  localparam int DIV_MAG_W = 48;
  localparam int DIV_DEN_W = 31;
  // Input register, one stage per quotient bit, output register.
  localparam int DIV_LAT   = DIV_MAG_W + 2;
  // Post-division stages of one axis.
  localparam int AX_LAT    = 7;

  localparam logic [DT_W-1:0]    TIME_STEP_RST = 31'd1092;
  localparam logic [LOSS_W-1:0]  LOSS_RST      = 17'd65536;
  localparam logic [BOUND_W-1:0] BOUND_RST     = 31'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_LOSS      = 2'd1,
    CFG_BOUND     = 2'd2
  } cfg_reg_t;

  // Clamp a 64-bit signed value into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Divide a 64-bit signed value by 2^16, rounding toward zero.
  function automatic logic signed [63:0] tz16(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> FRAC_W;
    if (v[63] && (v[FRAC_W-1:0] != '0)) begin
      s = s + 64'sd1;
    end
    return s;
  endfunction

endpackage

>>> design/vps_div.sv
module vps_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [vps_pkg::DIV_MAG_W:0] num,
  input  logic [vps_pkg::DIV_DEN_W-1:0]     den,
  output logic signed [vps_pkg::DATA_W-1:0] quo
);
  import vps_pkg::*;

  localparam int MW = DIV_MAG_W;
  localparam int DW = DIV_DEN_W;

  logic [DW-1:0] rem  [0:MW];
  logic [MW-1:0] work [0:MW];
  logic [DW-1:0] dens [0:MW];
  logic          negs [0:MW];
  logic          zers [0:MW];

  logic [DW-1:0] rem_next  [1:MW];
  logic [MW-1:0] work_next [1:MW];

  logic signed [MW:0] num_abs;

  assign num_abs = num[MW] ? -num : num;

  // One restoring step per stage: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [DW:0] shifted;
    logic [DW:0] diff;
    for (int s = 1; s <= MW; s++) begin
      shifted = {rem[s-1], work[s-1][MW-1]};
      diff    = shifted - {1'b0, dens[s-1]};
      if (shifted >= {1'b0, dens[s-1]}) begin
        rem_next[s]  = diff[DW-1:0];
        work_next[s] = {work[s-1][MW-2:0], 1'b1};
      end else begin
        rem_next[s]  = shifted[DW-1:0];
        work_next[s] = {work[s-1][MW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      work[0] <= num_abs[MW-1:0];
      dens[0] <= den;
      negs[0] <= num[MW];
      zers[0] <= (num == '0);
      for (int s = 1; s <= MW; s++) begin
        rem[s]  <= rem_next[s];
        work[s] <= work_next[s];
        dens[s] <= dens[s-1];
        negs[s] <= negs[s-1];
        zers[s] <= zers[s-1];
      end
    end
  end

  // A zero divisor drives every quotient bit high, which saturates by sign below.
  always_ff @(posedge clk) begin
    if (en) begin
      if (zers[MW]) begin
        quo <= '0;
      end else if (!negs[MW]) begin
        if (work[MW][MW-1:DATA_W-1] != '0) begin
          quo <= 32'sh7fffffff;
        end else begin
          quo <= work[MW][DATA_W-1:0];
        end
      end else begin
        if ((work[MW][MW-1:DATA_W] != '0) ||
            (work[MW][DATA_W-1] && (work[MW][DATA_W-2:0] != '0))) begin
          quo <= 32'sh80000000;
        end else begin
          quo <= -work[MW][DATA_W-1:0];
        end
      end
    end
  end

endmodule

>>> design/vps_axis.sv
module vps_axis (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [vps_pkg::DATA_W-1:0] acc,
  input  logic signed [vps_pkg::DATA_W-1:0] vel,
  input  logic signed [vps_pkg::DATA_W-1:0] pos,
  input  logic signed [vps_pkg::DATA_W:0]   dlt,
  input  logic [vps_pkg::MASS_W-1:0]        radius,
  input  logic [vps_pkg::LOSS_W-1:0]        loss,
  input  logic [vps_pkg::DT_W-1:0]          dt,
  input  logic [vps_pkg::DT_W-1:0]          dt2,
  input  logic [vps_pkg::BOUND_W-1:0]       bound,
  output logic signed [vps_pkg::DATA_W-1:0] pos_out,
  output logic signed [vps_pkg::DATA_W-1:0] last_out,
  output logic signed [vps_pkg::DATA_W-1:0] vel_out,
  output logic                              hit_out
);
  import vps_pkg::*;

  // Stage 1
  logic signed [49:0]       prod_l;
  logic signed [DATA_W-1:0] v1, p1;
  logic signed [DATA_W:0]   d1;
  logic [MASS_W-1:0]        r1;
  // Stage 2
  logic signed [DATA_W-1:0] acc2, v2, p2;
  logic signed [DATA_W:0]   d2;
  logic [MASS_W-1:0]        r2;
  // Stage 3
  logic signed [63:0]       prod_t;
  logic signed [DATA_W-1:0] v3, p3;
  logic signed [DATA_W:0]   d3;
  logic [MASS_W-1:0]        r3;
  // Stage 4
  logic signed [DATA_W-1:0] term, v4, p4;
  logic signed [DATA_W:0]   d4;
  logic [MASS_W-1:0]        r4;
  // Stage 5
  logic signed [DATA_W-1:0] x5, v5, p5;
  logic signed [63:0]       prod_v;
  logic [MASS_W-1:0]        r5;
  // Stage 6
  logic signed [DATA_W-1:0] xc6, v6, p6;
  logic signed [63:0]       vdt6;
  logic                     hit6;

  logic signed [63:0] prod_l_ext;
  logic signed [63:0] x_ext;
  logic signed [63:0] r_ext;
  logic signed [63:0] bw_ext;
  logic               hit_lo;
  logic               hit_hi;
  logic signed [63:0] clamp;

  assign prod_l_ext = {{14{prod_l[49]}}, prod_l};
  assign x_ext      = {{32{x5[DATA_W-1]}}, x5};
  assign r_ext      = {33'd0, r5};
  assign bw_ext     = {33'd0, bound};
  assign hit_lo     = (x_ext - r_ext) < -bw_ext;
  assign hit_hi     = (x_ext + r_ext) > bw_ext;
  assign clamp      = hit_lo ? (r_ext - bw_ext) : (bw_ext - r_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l <= acc * $signed({1'b0, loss});
      v1 <= vel; p1 <= pos; d1 <= dlt; r1 <= radius;

      acc2 <= sat32(tz16(prod_l_ext));
      v2 <= v1; p2 <= p1; d2 <= d1; r2 <= r1;

      prod_t <= acc2 * $signed({1'b0, dt2});
      v3 <= v2; p3 <= p2; d3 <= d2; r3 <= r2;

      term <= sat32(tz16(prod_t));
      v4 <= v3; p4 <= p3; d4 <= d3; r4 <= r3;

      x5 <= sat32({{32{p4[DATA_W-1]}}, p4} + {{31{d4[DATA_W]}}, d4} +
                  {{32{term[DATA_W-1]}}, term});
      prod_v <= v4 * $signed({1'b0, dt});
      v5 <= v4; p5 <= p4; r5 <= r4;

      // Low wall wins when the radius spans the whole arena.
      hit6 <= hit_lo || hit_hi;
      xc6  <= (hit_lo || hit_hi) ? clamp[DATA_W-1:0] : x5;
      vdt6 <= tz16(prod_v);
      v6 <= v5; p6 <= p5;

      pos_out <= xc6;
      hit_out <= hit6;
      if (hit6) begin
        last_out <= sat32({{32{xc6[DATA_W-1]}}, xc6} + vdt6);
        vel_out  <= sat32(-{{32{v6[DATA_W-1]}}, v6});
      end else begin
        last_out <= p6;
        vel_out  <= v6;
      end
    end
  end

endmodule

>>> design/verlet_particle_step_core.sv
// Position-Verlet step of one particle in a square arena, signed Q16.16.
//
// Input channel: in_valid / in_stall with pos, last, force per axis plus
// body_mass and body_radius. A transaction is taken when in_valid is high and
// in_stall low. Output channel: out_valid / out_stall with the new position,
// the position to use as "last" next step, the velocity and wall-hit flags.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// the time step, 1 the loss factor, 2 the half width of the arena. Write only
// while no transaction is in flight.
//
// The long dividers (force / mass and (pos - last) / dt) hold 50 register stages,
// the first one loaded at the accepting edge, then one per quotient bit and an
// output register; 7 more stages do the scaling multiplies, the position update
// and the wall handling. One transaction per cycle is sustained while the output
// is not stalled. When out_stall holds a valid result, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears the valid bits and loads the default register values.
module verlet_particle_step_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vps_pkg::DATA_W-1:0]    pos_x,
  input  logic signed [vps_pkg::DATA_W-1:0]    pos_y,
  input  logic signed [vps_pkg::DATA_W-1:0]    last_x,
  input  logic signed [vps_pkg::DATA_W-1:0]    last_y,
  input  logic signed [vps_pkg::DATA_W-1:0]    force_x,
  input  logic signed [vps_pkg::DATA_W-1:0]    force_y,
  input  logic [vps_pkg::MASS_W-1:0]           body_mass,
  input  logic [vps_pkg::MASS_W-1:0]           body_radius,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vps_pkg::DATA_W-1:0]    new_x,
  output logic signed [vps_pkg::DATA_W-1:0]    new_y,
  output logic signed [vps_pkg::DATA_W-1:0]    new_last_x,
  output logic signed [vps_pkg::DATA_W-1:0]    new_last_y,
  output logic signed [vps_pkg::DATA_W-1:0]    vel_x,
  output logic signed [vps_pkg::DATA_W-1:0]    vel_y,
  output logic                                 wall_hit_x,
  output logic                                 wall_hit_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vps_pkg::DATA_W-1:0]           cfg_data
);
  import vps_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W:0]   dx;
    logic signed [DATA_W:0]   dy;
    logic [MASS_W-1:0]        r;
  } side_t;

  logic [DT_W-1:0]    time_step;
  logic [LOSS_W-1:0]  loss_factor;
  logic [BOUND_W-1:0] bound_half_width;
  logic [DT_W-1:0]    dt2;
  logic [61:0]        dt_sq;

  logic en;

  logic signed [DATA_W:0] dx_in, dy_in;
  logic signed [DIV_MAG_W:0] fx_num, fy_num, dx_num, dy_num;
  logic signed [DATA_W-1:0] acc_x, acc_y, vq_x, vq_y;

  side_t side [0:DIV_LAT-1];
  logic  vld  [0:DIV_LAT+AX_LAT-1];

  // Advance the pipeline unless a finished result is held by the receiver.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[DIV_LAT+AX_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step        <= TIME_STEP_RST;
      loss_factor      <= LOSS_RST;
      bound_half_width <= BOUND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIME_STEP: time_step        <= cfg_data[DT_W-1:0];
        CFG_LOSS:      loss_factor      <= cfg_data[LOSS_W-1:0];
        CFG_BOUND:     bound_half_width <= cfg_data[BOUND_W-1:0];
        default:       ;
      endcase
    end
  end

  // dt^2 in Q16.16, saturated; tracks the register long before any item uses it.
  assign dt_sq = time_step * time_step;
  always_ff @(posedge clk) begin
    if (dt_sq[61:47] != '0) begin
      dt2 <= 31'h7fffffff;
    end else begin
      dt2 <= dt_sq[46:16];
    end
  end

  assign dx_in  = {pos_x[DATA_W-1], pos_x} - {last_x[DATA_W-1], last_x};
  assign dy_in  = {pos_y[DATA_W-1], pos_y} - {last_y[DATA_W-1], last_y};
  assign fx_num = {force_x[DATA_W-1], force_x, 16'd0};
  assign fy_num = {force_y[DATA_W-1], force_y, 16'd0};
  assign dx_num = {dx_in, 16'd0};
  assign dy_num = {dy_in, 16'd0};

  vps_div u_div_ax (.clk(clk), .en(en), .num(fx_num), .den(body_mass), .quo(acc_x));
  vps_div u_div_ay (.clk(clk), .en(en), .num(fy_num), .den(body_mass), .quo(acc_y));
  vps_div u_div_vx (.clk(clk), .en(en), .num(dx_num), .den(time_step), .quo(vq_x));
  vps_div u_div_vy (.clk(clk), .en(en), .num(dy_num), .den(time_step), .quo(vq_y));

  // Carry the operands the axis stages need alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{px: pos_x, py: pos_y, dx: dx_in, dy: dy_in, r: body_radius};
      for (int i = 1; i < DIV_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT + AX_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DIV_LAT + AX_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  vps_axis u_axis_x (
    .clk(clk), .en(en), .acc(acc_x), .vel(vq_x),
    .pos(side[DIV_LAT-1].px), .dlt(side[DIV_LAT-1].dx), .radius(side[DIV_LAT-1].r),
    .loss(loss_factor), .dt(time_step), .dt2(dt2), .bound(bound_half_width),
    .pos_out(new_x), .last_out(new_last_x), .vel_out(vel_x), .hit_out(wall_hit_x)
  );

  vps_axis u_axis_y (
    .clk(clk), .en(en), .acc(acc_y), .vel(vq_y),
    .pos(side[DIV_LAT-1].py), .dlt(side[DIV_LAT-1].dy), .radius(side[DIV_LAT-1].r),
    .loss(loss_factor), .dt(time_step), .dt2(dt2), .bound(bound_half_width),
    .pos_out(new_y), .last_out(new_last_y), .vel_out(vel_y), .hit_out(wall_hit_y)
  );

endmodule

>>> tb/tb_verlet_particle_step_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the Verlet particle step core.
// Every accepted input transaction is run through a local fixed-point model of
// the step (per axis: force / mass, loss scaling, position update, velocity,
// wall clamp and reflection). The expected result goes into a FIFO, and each
// output transaction is compared field by field with the oldest entry.
// Configuration registers are rewritten only when the pipeline has drained.
module tb_verlet_particle_step_core;
  import vps_pkg::*;

  localparam int  LIMIT_CYCLES = 600000;
  localparam int  DRAIN_CYCLES = 64;    // longer than the pipeline latency
  localparam int  N_RANDOM     = 1200;

  typedef struct {
    logic signed [DATA_W-1:0] px, py, lx, ly, fx, fy;
    logic [MASS_W-1:0]        mass, radius;
  } particle_t;

  typedef struct {
    logic signed [DATA_W-1:0] x, y, lx, ly, vx, vy;
    logic                     hx, hy;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, last_x = '0, last_y = '0;
  logic signed [DATA_W-1:0] force_x = '0, force_y = '0;
  logic [MASS_W-1:0] body_mass = '0, body_radius = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [DATA_W-1:0] new_x, new_y, new_last_x, new_last_y, vel_x, vel_y;
  logic wall_hit_x, wall_hit_y;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration registers.
  logic [DT_W-1:0]    dt_reg    = TIME_STEP_RST;
  logic [LOSS_W-1:0]  loss_reg  = LOSS_RST;
  logic [BOUND_W-1:0] bound_reg = BOUND_RST;

  step_result_t expected_steps[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_hits = 0, n_cfg = 0;
  int sender_idle_pct = 0, receiver_stall_pct = 0;
  int hold_off_cycles = 0;
  int cycles = 0;

  verlet_particle_step_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic longint clamp_q31(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point quotient num * 2^16 / den, saturating on a zero denominator.
  function automatic longint q_quotient(input longint num, input longint den);
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return clamp_q31(num * 65536 / den);
  endfunction

  // One axis of the Verlet step including wall reflection.
  function automatic void verlet_axis(input longint p, input longint l, input longint f,
                                      input longint m, input longint r,
                                      output logic signed [DATA_W-1:0] o_pos,
                                      output logic signed [DATA_W-1:0] o_last,
                                      output logic signed [DATA_W-1:0] o_vel,
                                      output logic o_hit);
    longint dt, bw, dsq, dt2, acc, term, x, v, nl;
    bit hit;
    dt  = longint'(dt_reg);
    bw  = longint'(bound_reg);
    dsq = (dt * dt) >>> 16;
    dt2 = (dsq > 64'sd2147483647) ? 64'sd2147483647 : dsq;
    acc = q_quotient(f, m);
    acc = clamp_q31(acc * longint'(loss_reg) / 65536);
    term = clamp_q31(acc * dt2 / 65536);
    x  = clamp_q31(p + (p - l) + term);
    v  = q_quotient(p - l, dt);
    nl = p;
    hit = 1'b0;
    // Low wall is tested first, so it wins when the body is wider than the arena.
    if (x - r < -bw) begin
      x = -bw + r;
      hit = 1'b1;
    end else if (x + r > bw) begin
      x = bw - r;
      hit = 1'b1;
    end
    if (hit) begin
      nl = clamp_q31(x + v * dt / 65536);
      v  = clamp_q31(-v);
    end
    o_pos  = x[DATA_W-1:0];
    o_last = nl[DATA_W-1:0];
    o_vel  = v[DATA_W-1:0];
    o_hit  = hit;
  endfunction

  function automatic step_result_t predict_step(input particle_t pt);
    step_result_t s;
    verlet_axis(pt.px, pt.lx, pt.fx, pt.mass, pt.radius, s.x, s.lx, s.vx, s.hx);
    verlet_axis(pt.py, pt.ly, pt.fy, pt.mass, pt.radius, s.y, s.ly, s.vy, s.hy);
    return s;
  endfunction

  // Drive one particle; idle first at the current sender rate. Valid stays
  // high on return so back-to-back transactions need no gap.
  task automatic send_particle(input particle_t pt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= pt.px; pos_y <= pt.py; last_x <= pt.lx; last_y <= pt.ly;
    force_x <= pt.fx; force_y <= pt.fy;
    body_mass <= pt.mass; body_radius <= pt.radius;
    do @(posedge clk); while (in_stall);
    expected_steps.push_back(predict_step(pt));
    n_sent++;
  endtask

  // Drop valid and wait at least one edge, then until every result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
  endtask

  // Write one register; only call with the pipeline drained.
  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIME_STEP: dt_reg    = value[DT_W-1:0];
      CFG_LOSS:      loss_reg  = value[LOSS_W-1:0];
      CFG_BOUND:     bound_reg = value[BOUND_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic particle_t make_particle(input int px, input int py, input int lx,
                                              input int ly, input int fx, input int fy,
                                              input int mass, input int radius);
    particle_t pt;
    pt.px = px; pt.py = py; pt.lx = lx; pt.ly = ly; pt.fx = fx; pt.fy = fy;
    pt.mass = mass[MASS_W-1:0]; pt.radius = radius[MASS_W-1:0];
    return pt;
  endfunction

  // Mostly plausible particles near the arena, some raw noise over all bits.
  function automatic particle_t random_particle();
    particle_t pt;
    int span;
    if ($urandom_range(3) == 0) begin
      pt.px = $urandom; pt.py = $urandom; pt.lx = $urandom; pt.ly = $urandom;
      pt.fx = $urandom; pt.fy = $urandom;
      pt.mass = MASS_W'($urandom); pt.radius = MASS_W'($urandom);
    end else begin
      span = (bound_reg > 31'd100000000) ? 100000000 : int'(bound_reg) + 200000;
      pt.px = $signed($urandom_range(2 * span)) - span;
      pt.py = $signed($urandom_range(2 * span)) - span;
      pt.lx = pt.px + $signed($urandom_range(8000)) - 4000;
      pt.ly = pt.py + $signed($urandom_range(8000)) - 4000;
      pt.fx = $signed($urandom_range(1 << 22)) - (1 << 21);
      pt.fy = $signed($urandom_range(1 << 22)) - (1 << 21);
      pt.mass = ($urandom_range(19) == 0) ? '0 : MASS_W'($urandom_range(1 << 20, 1));
      pt.radius = MASS_W'($urandom_range(1 << 17));
    end
    return pt;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare every output transaction with the oldest expectation.
  always @(posedge clk) begin
    step_result_t s;
    if (!rst && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, actual new_x %0d", $time, new_x);
      end else begin
        s = expected_steps.pop_front();
        check_field("new_x", s.x, new_x);
        check_field("new_y", s.y, new_y);
        check_field("new_last_x", s.lx, new_last_x);
        check_field("new_last_y", s.ly, new_last_y);
        check_field("vel_x", s.vx, vel_x);
        check_field("vel_y", s.vy, vel_y);
        check_field("wall_hit_x", s.hx, wall_hit_x);
        check_field("wall_hit_y", s.hy, wall_hit_y);
        n_checked++;
        if (s.hx || s.hy) n_hits++;
      end
    end
  end

  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // Zero mass with positive, negative and zero force.
    send_particle(make_particle(0, 0, 0, 0, 65536, -65536, 0, 0));
    send_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0));
    // Field extremes, saturating everywhere.
    send_particle(make_particle(mx, mn, mn, mx, mx, mn, 31'h7fffffff, 31'h7fffffff));
    send_particle(make_particle(mn, mx, mx, mn, mn, mx, 1, 0));
    send_particle(make_particle(-1, -1, 0, 0, -1, -1, 31'h7fffffff, 1));
    // Low and high walls on each axis, and a body wider than the arena.
    send_particle(make_particle(-700000, 700000, -690000, 690000, 0, 0, 65536, 0));
    send_particle(make_particle(600000, -600000, 590000, -590000, 0, 0, 65536, 65536));
    send_particle(make_particle(0, 0, 1000, -1000, 0, 0, 65536, 31'h7fffffff));
    // Resting inside the arena.
    send_particle(make_particle(65536, -65536, 65536, -65536, 100, -100, 65536, 100));
    // Loss above 1.0 and zero loss.
    write_reg(CFG_LOSS, 32'h1ffff);
    send_particle(make_particle(0, 0, 0, 0, mx, mn, 1, 0));
    write_reg(CFG_LOSS, 32'd0);
    send_particle(make_particle(100, 100, 50, 150, mx, mn, 1, 0));
    // Zero time step: velocity saturates by the sign of the displacement.
    write_reg(CFG_TIME_STEP, 32'd0);
    send_particle(make_particle(10, -10, 5, -5, 0, 0, 65536, 0));
    send_particle(make_particle(10, 10, 10, 10, 0, 0, 65536, 0));
    // Largest time step and tightest arena.
    write_reg(CFG_TIME_STEP, 32'h7fffffff);
    write_reg(CFG_LOSS, DATA_W'(LOSS_RST));
    write_reg(CFG_BOUND, 32'd1);
    send_particle(make_particle(3, -3, 0, 0, 65536, -65536, 65536, 0));
    send_particle(make_particle(1, -1, 1, -1, 0, 0, 65536, 1));
    write_reg(CFG_BOUND, 32'h7fffffff);
    send_particle(make_particle(mx, mn, mn, mx, 0, 0, 65536, 0));
    send_particle(make_particle(100, -100, 0, 0, 65536, 65536, 65536, 5));
    wait_drained();
  endtask

  // Random stream under one register setting and one idle/stall mix.
  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send_particle(random_particle());
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering, so the pipeline
  // fills and back-pressures the input; then pause until it drains.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles <= 300;
    repeat (150) send_particle(random_particle());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();

    write_reg(CFG_TIME_STEP, DATA_W'(TIME_STEP_RST));
    write_reg(CFG_LOSS, DATA_W'(LOSS_RST));
    write_reg(CFG_BOUND, DATA_W'(BOUND_RST));
    test_random(N_RANDOM / 4, 0, 0);
    test_backpressure();
    write_reg(CFG_TIME_STEP, 32'd65536);
    write_reg(CFG_LOSS, 32'd49152);
    test_random(N_RANDOM / 4, 51, 0);
    write_reg(CFG_BOUND, 32'd6553600);
    write_reg(CFG_TIME_STEP, 32'd7);
    test_random(N_RANDOM / 4, 0, 51);
    write_reg(CFG_TIME_STEP, 32'h7fffffff);
    write_reg(CFG_LOSS, 32'h1ffff);
    write_reg(CFG_BOUND, 32'd1);
    test_random(N_RANDOM / 8, 30, 30);
    write_reg(CFG_TIME_STEP, 32'd1);
    write_reg(CFG_LOSS, 32'd0);
    write_reg(CFG_BOUND, 32'h7fffffff);
    test_random(N_RANDOM / 8, 30, 30);

    receiver_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d particle steps, checked %0d results (%0d with wall contact),",
             n_sent, n_checked, n_hits);
    $display("%0d register writes across idle, stall and back-pressure phases.", n_cfg);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
